[rtl/skf_pkg.sv]
`default_nettype none

package skf_pkg;

    // Field widths
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int GAIN_SHIFT = 16;
    localparam int CFG_IDX_W  = 2;

    // Gain of exactly one in Q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // Quotient bits produced by the divider, one per step
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE   = 2'd3;

    // Configuration reset values (Q16.16)
    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE      = 32'd131072;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE  = 32'd655360;
    localparam logic [DATA_W-1:0] RST_INITIAL_COVARIANCE = 32'd0;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd0;

    // Input request payload
    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     first_of_run;
        logic                     last_of_run;
    } t_skf_in;

    // Output request payload
    typedef struct packed {
        logic signed [DATA_W-1:0] estimate;
        logic [GAIN_W-1:0]        gain;
        logic                     fault;
        logic                     run_end;
    } t_skf_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_start;
        logic take_gain;
        logic multiply;
        logic commit;
    } t_skf_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;
    } t_skf_sts;

endpackage

`default_nettype wire

[rtl/scalar_kalman_filter.sv]
// One-dimensional Kalman filter in fixed point. Each sample request yields one
// result request carrying the new estimate (signed Q16.16), the gain used
// (Q1.16, 65536 = 1.0), a sticky fault flag and an echo of last_of_run. A
// request with first_of_run set reloads estimate and covariance from the
// initial_* registers and clears the fault flag before it is processed.
// Covariance overflow, a zero gain denominator or an estimate clamp set the
// fault flag. The block works on one sample at a time; the gain comes from
// a bit-serial divider. Each sample passes through these steps in order:
// accepting and loading the sample, starting the divider, handing over its
// quotient, capturing the gain and innovation, forming both products in the
// multiply step, and writing the update once the output register is free.
// A finished result waits in an output register while the next sample runs.
// Configuration registers may be written only while the block is idle.
`default_nettype none

module scalar_kalman_filter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire skf_pkg::t_skf_in                i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output skf_pkg::t_skf_out                    o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]      i_cfg_data
);
    import skf_pkg::*;

    t_skf_cmd cmd;
    t_skf_sts sts;

    skf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    skf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_out)
    );

endmodule

`default_nettype wire

[rtl/skf_div.sv]
`default_nettype none

// Restoring divider: floor(p1 * 2^16 / den), one quotient bit per cycle.
// The quotient never exceeds 2^16, so only the low 17 bits are developed.
module skf_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [skf_pkg::DATA_W-1:0]      i_p1,
    input  wire logic [skf_pkg::DATA_W:0]        i_den,
    output logic                                 o_done,
    output logic [skf_pkg::GAIN_W-1:0]           o_quotient
);
    import skf_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      r_rem;
    logic [DATA_W:0]      r_den;
    logic [GAIN_W-1:0]    r_bits;
    logic [GAIN_W-1:0]    r_quo;

    logic [DATA_W+1:0]    trial;
    logic [DATA_W+1:0]    trial_sub;
    logic                 ge;

    // One trial subtraction
    assign trial     = {r_rem, r_bits[GAIN_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign ge        = (trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // dividend bits above the quotient window start the remainder
            r_rem  <= {1'b0, i_p1[DATA_W-1:1]};
            r_bits <= {i_p1[0], {(GAIN_W-1){1'b0}}};
            r_den  <= i_den;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? trial_sub[DATA_W:0] : trial[DATA_W:0];
            r_bits <= {r_bits[GAIN_W-2:0], 1'b0};
            r_quo  <= {r_quo[GAIN_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

[rtl/skf_datapath.sv]
`default_nettype none

module skf_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire skf_pkg::t_skf_cmd               i_cmd,
    output skf_pkg::t_skf_sts                    o_sts,
    input  wire skf_pkg::t_skf_in                i_in,
    input  wire logic                            i_cfg_we,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]      i_cfg_data,
    output skf_pkg::t_skf_out                    o_result
);
    import skf_pkg::*;

    // Configuration
    logic [DATA_W-1:0]        r_q;
    logic [DATA_W-1:0]        r_r;
    logic [DATA_W-1:0]        r_init_cov;
    logic signed [DATA_W-1:0] r_init_est;

    // Filter state
    logic signed [DATA_W-1:0] r_x;
    logic [DATA_W-1:0]        r_p;
    logic                     r_fault;

    // Per-request working registers
    logic signed [DATA_W-1:0] r_sample;
    logic                     r_last;
    logic [DATA_W-1:0]        r_p1;
    logic                     r_den_zero;
    logic [GAIN_W-1:0]        r_k;
    logic signed [DATA_W:0]   r_diff;
    logic signed [DATA_W+GAIN_W+1:0] r_prod_x;
    logic [DATA_W+GAIN_W-1:0] r_prod_p;
    t_skf_out                 r_out;

    logic signed [DATA_W-1:0] x_start;
    logic [DATA_W-1:0]        p_start;
    logic                     f_start;
    logic [DATA_W:0]          p_sum;
    logic [DATA_W-1:0]        p1_sat;
    logic [DATA_W:0]          den;
    logic                     div_done;
    logic [GAIN_W-1:0]        div_quo;
    logic signed [GAIN_W:0]   k_signed;
    logic [GAIN_W-1:0]        k_comp;
    logic signed [DATA_W+2:0] corr;
    logic signed [DATA_W+2:0] xn;
    logic                     xn_hi;
    logic                     xn_lo;
    logic signed [DATA_W-1:0] xn_sat;
    logic                     fault_new;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q        <= RST_PROCESS_NOISE;
            r_r        <= RST_MEASUREMENT_NOISE;
            r_init_cov <= RST_INITIAL_COVARIANCE;
            r_init_est <= RST_INITIAL_ESTIMATE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PROCESS_NOISE:      r_q        <= i_cfg_data;
                CFG_MEASUREMENT_NOISE:  r_r        <= i_cfg_data;
                CFG_INITIAL_COVARIANCE: r_init_cov <= i_cfg_data;
                CFG_INITIAL_ESTIMATE:   r_init_est <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Start of run reload and predicted covariance, saturating
    assign x_start = i_in.first_of_run ? r_init_est : r_x;
    assign p_start = i_in.first_of_run ? r_init_cov : r_p;
    assign f_start = i_in.first_of_run ? 1'b0 : r_fault;
    assign p_sum   = {1'b0, p_start} + {1'b0, r_q};
    assign p1_sat  = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

    // Gain denominator
    assign den = {1'b0, r_p1} + {1'b0, r_r};

    skf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_p1       (r_p1),
        .i_den      (den),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign o_sts.div_done = div_done;

    // Multiplier operands
    assign k_signed = {1'b0, r_k};
    assign k_comp   = GAIN_ONE - r_k;

    // Estimate update: floor shift, then clamp to 32-bit signed
    assign corr      = r_prod_x[DATA_W+GAIN_W+1:GAIN_SHIFT];
    assign xn        = {{3{r_x[DATA_W-1]}}, r_x} + corr;
    assign xn_hi     = !xn[DATA_W+2] && (xn[DATA_W+1:DATA_W-1] != 3'b000);
    assign xn_lo     = xn[DATA_W+2] && (xn[DATA_W+1:DATA_W-1] != 3'b111);
    assign xn_sat    = xn_hi ? {1'b0, {(DATA_W-1){1'b1}}} :
                       xn_lo ? {1'b1, {(DATA_W-1){1'b0}}} : xn[DATA_W-1:0];
    assign fault_new = r_fault | xn_hi | xn_lo;

    // Filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_p     <= '0;
            r_fault <= 1'b0;
        end else if (i_cmd.load) begin
            r_x     <= x_start;
            r_fault <= f_start | p_sum[DATA_W];
        end else if (i_cmd.take_gain) begin
            r_fault <= r_fault | r_den_zero;
        end else if (i_cmd.commit) begin
            r_x     <= xn_sat;
            r_p     <= r_prod_p[DATA_W+GAIN_SHIFT-1:GAIN_SHIFT];
            r_fault <= fault_new;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample   <= i_in.sample;
            r_last     <= i_in.last_of_run;
            r_p1       <= p1_sat;
            r_den_zero <= (p1_sat == '0) && (r_r == '0);
        end
        if (i_cmd.take_gain) begin
            r_k    <= r_den_zero ? '0 : div_quo;
            r_diff <= {r_sample[DATA_W-1], r_sample} - {r_x[DATA_W-1], r_x};
        end
        if (i_cmd.multiply) begin
            r_prod_x <= k_signed * r_diff;
            r_prod_p <= k_comp * r_p1;
        end
        if (i_cmd.commit) begin
            r_out.estimate <= xn_sat;
            r_out.gain     <= r_k;
            r_out.fault    <= fault_new;
            r_out.run_end  <= r_last;
        end
    end

    assign o_result = r_out;

    // Checks
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_out.gain <= GAIN_ONE))
        else $error("gain above one");

    a_zero_den_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_den_zero) |=> (r_out.fault && r_out.gain == '0))
        else $error("zero divisor not flagged");

    a_cov_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_p <= $past(r_p1)))
        else $error("covariance grew in update");

endmodule

`default_nettype wire

[rtl/skf_ctrl.sv]
`default_nettype none

module skf_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output skf_pkg::t_skf_cmd        o_cmd,
    input  wire skf_pkg::t_skf_sts   i_sts
);
    import skf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_GAIN  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_GAIN;
                end
            end
            S_GAIN: begin
                o_cmd.take_gain = 1'b1;
                n_state         = S_MUL;
            end
            S_MUL: begin
                o_cmd.multiply = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Checks
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    a_result_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WRITE))
        else $error("result appeared without a commit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_out_valid && !i_out_ready) |=> (r_state == S_WRITE))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/kalman_checker.sv]
// Watches the sample and result channels and the register port of the filter,
// predicts every result from its own copy of the filter state and compares.
module kalman_checker
    import skf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_ready,
    input  wire t_skf_in              i_in,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_ready,
    input  wire t_skf_out             i_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam longint EST_MAX = 64'sd2147483647;
    localparam longint EST_MIN = -64'sd2147483648;

    // Shadow registers
    bit [31:0]        q_noise;
    bit [31:0]        r_noise;
    bit [31:0]        p_init;
    bit signed [31:0] x_init;

    // Shadow filter state
    bit signed [31:0] x_est;
    bit [31:0]        p_cov;
    bit [16:0]        k_last;
    bit               fault_flag;

    t_skf_out predicted_updates[$];
    int       fail_total = 0;
    int       pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    // One filter step on the shadow state
    function automatic t_skf_out kalman_update(input t_skf_in req);
        t_skf_out  res;
        bit [63:0] p_pred;
        bit [63:0] denom;
        bit [63:0] k;
        bit [63:0] p_next;
        longint    x_old;
        longint    diff;
        longint    x_new;
        if (req.first_of_run) begin
            x_est      = x_init;
            p_cov      = p_init;
            k_last     = '0;
            fault_flag = 1'b0;
        end
        // prediction, saturating on overflow
        p_pred = {32'd0, p_cov} + {32'd0, q_noise};
        if (p_pred > 64'hFFFF_FFFF) begin
            p_pred     = 64'hFFFF_FFFF;
            fault_flag = 1'b1;
        end
        // gain, zero when the denominator vanishes
        denom = p_pred + {32'd0, r_noise};
        if (denom == 64'd0) begin
            k          = 64'd0;
            fault_flag = 1'b1;
        end else begin
            k = (p_pred << GAIN_SHIFT) / denom;
            if (k > 64'(GAIN_ONE))
                k = 64'(GAIN_ONE);
        end
        // estimate correction, floor toward minus infinity
        x_old = longint'(x_est);
        diff  = longint'($signed(req.sample)) - x_old;
        x_new = x_old + ((longint'(k) * diff) >>> GAIN_SHIFT);
        if (x_new > EST_MAX) begin
            x_new      = EST_MAX;
            fault_flag = 1'b1;
        end else if (x_new < EST_MIN) begin
            x_new      = EST_MIN;
            fault_flag = 1'b1;
        end
        p_next = ((64'(GAIN_ONE) - k) * p_pred) >> GAIN_SHIFT;
        x_est  = x_new[31:0];
        p_cov  = p_next[31:0];
        k_last = k[16:0];
        res.estimate = x_est;
        res.gain     = k_last;
        res.fault    = fault_flag;
        res.run_end  = req.last_of_run;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_skf_out want;
        if (!i_rst_n) begin
            q_noise    = RST_PROCESS_NOISE;
            r_noise    = RST_MEASUREMENT_NOISE;
            p_init     = RST_INITIAL_COVARIANCE;
            x_init     = RST_INITIAL_ESTIMATE;
            x_est      = '0;
            p_cov      = '0;
            k_last     = '0;
            fault_flag = 1'b0;
            predicted_updates.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE:      q_noise = i_cfg_data;
                    CFG_MEASUREMENT_NOISE:  r_noise = i_cfg_data;
                    CFG_INITIAL_COVARIANCE: p_init  = i_cfg_data;
                    CFG_INITIAL_ESTIMATE:   x_init  = i_cfg_data;
                    default: ;
                endcase
            end
            // sample request accepted
            if (i_in_valid && i_in_ready)
                predicted_updates.push_back(kalman_update(i_in));
            // result request accepted
            if (i_out_valid && i_out_ready) begin
                if (predicted_updates.size() == 0) begin
                    $error("result with nothing pending: estimate %0d gain %0d",
                           $signed(i_out.estimate), i_out.gain);
                    fail_total++;
                end else begin
                    want = predicted_updates.pop_front();
                    if (i_out.estimate !== want.estimate) begin
                        $error("estimate mismatch: expected %0d, got %0d",
                               $signed(want.estimate), $signed(i_out.estimate));
                        fail_total++;
                    end
                    if (i_out.gain !== want.gain) begin
                        $error("gain mismatch: expected %0d, got %0d",
                               want.gain, i_out.gain);
                        fail_total++;
                    end
                    if (i_out.fault !== want.fault) begin
                        $error("fault mismatch: expected %0d, got %0d",
                               want.fault, i_out.fault);
                        fail_total++;
                    end
                    if (i_out.run_end !== want.run_end) begin
                        $error("run_end mismatch: expected %0d, got %0d",
                               want.run_end, i_out.run_end);
                        fail_total++;
                    end
                end
            end
        end
        pending_total = predicted_updates.size();
    end

endmodule

[tb/tb_scalar_kalman_filter.sv]
module tb_scalar_kalman_filter;
    import skf_pkg::*;

    localparam int          SAMPLE_TARGET = 1950;
    localparam int          DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_skf_in              in_req = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_skf_out             out_res;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    int          fail_count;
    int          pending;
    int unsigned cycle_count = 0;
    int          samples_sent = 0;
    bit          send_eager = 1'b0;
    bit          ready_eager = 1'b0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;

    scalar_kalman_filter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    kalman_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_res),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stall after each accepted result, with eager stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                out_ready <= 1'b1;
        end else if (out_ready && out_valid) begin
            if ($urandom_range(0, 63) == 0)
                ready_eager <= !ready_eager;
            stall_draw = ready_eager ? 0 : $urandom_range(0, 16);
            if (stall_draw != 0) begin
                out_ready  <= 1'b0;
                stall_left <= stall_draw;
            end
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Send one sample request; valid stays up when the next one follows at once
    task automatic send_sample(input logic [31:0] value, input logic first,
                               input logic last);
        int gap;
        if ($urandom_range(0, 47) == 0)
            send_eager = !send_eager;
        gap = send_eager ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_req.sample         <= value;
        in_req.first_of_run   <= first;
        in_req.last_of_run    <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Wait until every pending result is out and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic cfg_release();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_filter(input logic [31:0] q, input logic [31:0] r,
                              input logic [31:0] p0, input logic [31:0] x0);
        wait_idle();
        cfg_write(CFG_PROCESS_NOISE, q);
        cfg_write(CFG_MEASUREMENT_NOISE, r);
        cfg_write(CFG_INITIAL_COVARIANCE, p0);
        cfg_write(CFG_INITIAL_ESTIMATE, x0);
        cfg_release();
    endtask

    // Noise and covariance: mostly moderate, sometimes at the extremes
    function automatic logic [31:0] pick_noise();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3, 4, 5: return $urandom_range(0, 32'h0010_0000);
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample(input logic [31:0] level);
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return $urandom;
            default: return level + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    initial begin
        int          run_len;
        int          phase_end;
        logic [31:0] level;
        logic        first;
        logic        last;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings; the first three samples carry no first_of_run and continue from the reset state
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b1);
        send_sample(32'h0001_0000, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h1234_5678, 1'b1, 1'b1);

        // All noise zero: zero divisor, fault stays set
        set_filter(32'h0, 32'h0, 32'h0, 32'h0);
        send_sample(32'h0005_0000, 1'b1, 1'b0);
        send_sample(32'hFFFB_0000, 1'b0, 1'b1);

        // Covariance overflow with unit gain
        set_filter(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b1);

        // Tiny gain from the largest measurement noise
        set_filter(32'h1, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);

        // Gain near one with the widest possible innovation
        set_filter(32'hFFFF_FFFF, 32'h1, 32'h0, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b1, 1'b1);

        // A short ordinary run
        set_filter(32'h0002_0000, 32'h000A_0000, 32'h0001_0000, 32'h0);
        send_sample(32'h0003_0000, 1'b1, 1'b0);
        send_sample(32'h0002_8000, 1'b0, 1'b0);
        send_sample(32'hFFFF_0000, 1'b0, 1'b0);
        send_sample(32'h0004_4000, 1'b0, 1'b1);

        // Random phases of runs under random settings
        while (samples_sent < SAMPLE_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 9) < 7) cfg_write(CFG_PROCESS_NOISE, pick_noise());
            if ($urandom_range(0, 9) < 7) cfg_write(CFG_MEASUREMENT_NOISE, pick_noise());
            if ($urandom_range(0, 9) < 7) cfg_write(CFG_INITIAL_COVARIANCE, pick_noise());
            cfg_write(CFG_INITIAL_ESTIMATE, pick_level());
            cfg_release();
            phase_end = samples_sent + $urandom_range(60, 180);
            while (samples_sent < phase_end && samples_sent < SAMPLE_TARGET) begin
                run_len = $urandom_range(1, 40);
                level   = pick_level();
                for (int i = 0; i < run_len; i++) begin
                    first = (i == 0) && ($urandom_range(0, 9) != 0);
                    last  = (i == run_len - 1);
                    // occasional stray markers mid run
                    if ($urandom_range(0, 11) == 0) begin
                        first = $urandom_range(0, 1);
                        last  = $urandom_range(0, 1);
                    end
                    send_sample(pick_sample(level), first, last);
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
